>>> sv/ccs_pkg.sv
// Package for the contactor connect sequencer: types, codes and reset values.
package ccs_pkg;

    // Width of the wrapping time base used for send scheduling
    localparam int unsigned TIME_WIDTH = 32;
    // APB address width: seven 32-bit registers at byte offsets 0..24
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned DATA_W     = 32;

    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [5:0]            count_t;

    localparam count_t COUNT_MAX    = 6'd63;
    localparam logic [3:0] STATE_NIBBLE = 4'hf;

    // Event kinds of an input word
    typedef enum logic [1:0] {
        FN_TICK   = 2'd0,
        FN_STATUS = 2'd1,
        FN_POLL   = 2'd2
    } func_t;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_INIT       = 3'd0,
        PH_CLEAR      = 3'd1,
        PH_CONNECTING = 3'd2,
        PH_PENDING    = 3'd3,
        PH_CONNECTED  = 3'd4
    } phase_t;

    // Register indexes (byte address = 4 * index)
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_KEEPALIVE   = 3'd0;
    localparam reg_idx_t REG_QUICK       = 3'd1;
    localparam reg_idx_t REG_RESET_CMD   = 3'd2;
    localparam reg_idx_t REG_CONNECT_CMD = 3'd3;
    localparam reg_idx_t REG_CONN_CODE   = 3'd4;
    localparam reg_idx_t REG_RETRY_LIMIT = 3'd5;
    localparam reg_idx_t REG_TIMEOUT     = 3'd6;

    // Reset values of the registers
    localparam logic [15:0] RST_KEEPALIVE   = 16'd128;
    localparam logic [15:0] RST_QUICK       = 16'd16;
    localparam logic [7:0]  RST_RESET_CMD   = 8'd0;
    localparam logic [7:0]  RST_CONNECT_CMD = 8'd1;
    localparam logic [3:0]  RST_CONN_CODE   = 4'd1;
    localparam logic [3:0]  RST_RETRY_LIMIT = 4'd4;
    localparam logic [5:0]  RST_TIMEOUT     = 6'd30;

    // Configuration as seen by the sequencer core
    typedef struct packed {
        logic [15:0] keepalive_period;
        logic [15:0] quick_period;
        logic [7:0]  reset_command;
        logic [7:0]  connect_command;
        logic [3:0]  connected_code;
        logic [3:0]  fault_retry_limit;
        logic [5:0]  connect_timeout;
    } cfg_t;

endpackage

>>> sv/ccs_ifs.sv
// Handshake channel interfaces for input events and results.
interface ccs_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] time_now;
    logic        connect_request;
    logic [7:0]  status_byte;
    logic [7:0]  fault_byte;

    modport source (output valid, output func, output time_now, output connect_request,
                    output status_byte, output fault_byte, input ready);
    modport sink   (input valid, input func, input time_now, input connect_request,
                    input status_byte, input fault_byte, output ready);
endinterface

interface ccs_result_if;
    logic       valid;
    logic       ready;
    logic       send_valid;
    logic [7:0] command_byte;
    logic [2:0] phase_now;
    logic [7:0] last_status;

    modport source (output valid, output send_valid, output command_byte,
                    output phase_now, output last_status, input ready);
    modport sink   (input valid, input send_valid, input command_byte,
                    input phase_now, input last_status, output ready);
endinterface

>>> sv/contactor_connect_sequencer_top.sv
// Top level of the contactor connect sequencer.
// Path: a word is held in the input register, then its result in the result register;
// the phase and schedule update as the result register loads.
// Throughput: one word per cycle while the result channel is ready; a result not taken stalls the input.
// Reset (rst_n, asynchronous, low): phase init, schedule and counters cleared,
// no send pending, registers back to their reset values, both channels empty.
module contactor_connect_sequencer_top
    import ccs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    ccs_item_if.sink          item,
    ccs_result_if.source      result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t cfg;

    // configuration registers
    ccs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer datapath
    ccs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .result (result)
    );

endmodule

>>> sv/ccs_cfg.sv
// APB register file holding the sequencer configuration.
module ccs_cfg
    import ccs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_KEEPALIVE:   cfg_next.keepalive_period  = pwdata[15:0];
                REG_QUICK:       cfg_next.quick_period      = pwdata[15:0];
                REG_RESET_CMD:   cfg_next.reset_command     = pwdata[7:0];
                REG_CONNECT_CMD: cfg_next.connect_command   = pwdata[7:0];
                REG_CONN_CODE:   cfg_next.connected_code    = pwdata[3:0];
                REG_RETRY_LIMIT: cfg_next.fault_retry_limit = pwdata[3:0];
                REG_TIMEOUT:     cfg_next.connect_timeout   = pwdata[5:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.keepalive_period  <= RST_KEEPALIVE;
            cfg_reg.quick_period      <= RST_QUICK;
            cfg_reg.reset_command     <= RST_RESET_CMD;
            cfg_reg.connect_command   <= RST_CONNECT_CMD;
            cfg_reg.connected_code    <= RST_CONN_CODE;
            cfg_reg.fault_retry_limit <= RST_RETRY_LIMIT;
            cfg_reg.connect_timeout   <= RST_TIMEOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read-back mux
    always_comb
    begin
        case (idx)
            REG_KEEPALIVE:   prdata = DATA_W'(cfg_reg.keepalive_period);
            REG_QUICK:       prdata = DATA_W'(cfg_reg.quick_period);
            REG_RESET_CMD:   prdata = DATA_W'(cfg_reg.reset_command);
            REG_CONNECT_CMD: prdata = DATA_W'(cfg_reg.connect_command);
            REG_CONN_CODE:   prdata = DATA_W'(cfg_reg.connected_code);
            REG_RETRY_LIMIT: prdata = DATA_W'(cfg_reg.fault_retry_limit);
            REG_TIMEOUT:     prdata = DATA_W'(cfg_reg.connect_timeout);
            default:         prdata = '0;
        endcase
    end

endmodule

>>> sv/ccs_core.sv
// Sequencer core: input register, phase/schedule logic, state and result register.
module ccs_core
    import ccs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    ccs_item_if.sink     item,
    ccs_result_if.source result
);

    // input register
    logic        s1_valid_reg;
    logic        s1_valid_next;
    func_t       s1_func_reg;
    time_t       s1_now_reg;
    logic        s1_req_reg;
    logic [7:0]  s1_status_reg;
    logic [7:0]  s1_fault_reg;

    // sequencer state
    phase_t      phase_reg;
    phase_t      phase_next;
    time_t       nst_reg;
    time_t       nst_next;
    logic [7:0]  pend_reg;
    logic [7:0]  pend_next;
    count_t      att_reg;
    count_t      att_next;
    logic        sp_reg;
    logic        sp_next;
    logic [7:0]  rs_reg;
    logic [7:0]  rs_next;

    // result register
    logic        res_valid_reg;
    logic        res_valid_next;
    logic        res_send_reg;
    logic [7:0]  res_cmd_reg;
    logic [2:0]  res_phase_reg;
    logic [7:0]  res_status_reg;

    logic        in_take;
    logic        adv;
    logic        send;
    logic [7:0]  cmd;
    time_t       diff;
    logic        ahead;

    function automatic count_t sat_inc(input count_t c);
        sat_inc = (c < COUNT_MAX) ? c + 6'd1 : c;
    endfunction

    // handshake: the result register frees itself as soon as it is taken
    assign adv        = s1_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || adv;
    assign in_take    = item.valid && item.ready;

    assign s1_valid_next  = in_take || (s1_valid_reg && !adv);
    assign res_valid_next = adv || (res_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // capture the input word
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_func_reg   <= func_t'(item.func);
            s1_now_reg    <= time_t'(item.time_now);
            s1_req_reg    <= item.connect_request;
            s1_status_reg <= item.status_byte;
            s1_fault_reg  <= item.fault_byte;
        end
    end

    // wrapping compare: next send still ahead of now
    assign diff  = nst_reg - s1_now_reg;
    assign ahead = (diff != '0) && !diff[TIME_WIDTH-1];

    // next state
    always_comb
    begin
        count_t att_a;
        count_t att_b;
        logic   enter_conn;

        phase_next = phase_reg;
        nst_next   = nst_reg;
        pend_next  = pend_reg;
        att_next   = att_reg;
        sp_next    = sp_reg;
        rs_next    = rs_reg;
        att_a      = att_reg;
        att_b      = att_reg;
        enter_conn = 1'b0;

        if (adv)
        begin
            case (s1_func_reg)
                FN_TICK:
                begin
                    if (phase_reg == PH_INIT)
                    begin
                        nst_next   = s1_now_reg + time_t'(cfg.keepalive_period);
                        pend_next  = cfg.reset_command;
                        att_next   = '0;
                        sp_next    = 1'b1;
                        phase_next = PH_CLEAR;
                    end
                    else if (!ahead)
                    begin
                        nst_next = s1_now_reg + time_t'(cfg.keepalive_period);
                        sp_next  = 1'b1;
                    end
                end
                FN_STATUS:
                begin
                    rs_next  = s1_status_reg;
                    nst_next = s1_now_reg + time_t'(cfg.quick_period);
                    if (!s1_req_reg)
                    begin
                        pend_next  = cfg.reset_command;
                        phase_next = PH_CLEAR;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_CLEAR:
                            begin
                                // retry fault clearing while a fault remains, until the limit is reached
                                att_b = sat_inc(att_reg);
                                if (s1_fault_reg != 8'd0 &&
                                    att_b < count_t'(cfg.fault_retry_limit))
                                begin
                                    att_next = att_b;
                                end
                                else
                                begin
                                    att_a      = '0;
                                    enter_conn = 1'b1;
                                end
                            end
                            PH_CONNECTING:
                            begin
                                enter_conn = 1'b1;
                            end
                            PH_PENDING:
                            begin
                                phase_next = PH_CONNECTED;
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase

                        // connect check, shared by both entry routes
                        if (enter_conn)
                        begin
                            pend_next = cfg.connect_command;
                            if ((s1_status_reg[3:0] & STATE_NIBBLE) != cfg.connected_code)
                            begin
                                att_b      = sat_inc(att_a);
                                att_next   = att_b;
                                phase_next = (att_b > cfg.connect_timeout) ? PH_INIT
                                                                           : PH_CONNECTING;
                            end
                            else
                            begin
                                att_next   = att_a;
                                phase_next = PH_PENDING;
                            end
                        end
                    end
                end
                FN_POLL:
                begin
                    sp_next = 1'b0;
                end
                default:
                begin
                    sp_next = sp_reg;
                end
            endcase
        end
    end

    // outputs of this word
    always_comb
    begin
        send = 1'b0;
        cmd  = 8'd0;
        if (s1_func_reg == FN_POLL && sp_reg)
        begin
            send = 1'b1;
            cmd  = pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_INIT;
            nst_reg   <= '0;
            pend_reg  <= RST_RESET_CMD;
            att_reg   <= '0;
            sp_reg    <= 1'b0;
            rs_reg    <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            nst_reg   <= nst_next;
            pend_reg  <= pend_next;
            att_reg   <= att_next;
            sp_reg    <= sp_next;
            rs_reg    <= rs_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_send_reg   <= send;
            res_cmd_reg    <= cmd;
            res_phase_reg  <= phase_next;
            res_status_reg <= rs_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.send_valid   = res_send_reg;
    assign result.command_byte = res_cmd_reg;
    assign result.phase_now    = res_phase_reg;
    assign result.last_status  = res_status_reg;

    // a poll always consumes the pending send
    a_poll_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_func_reg == FN_POLL) |=> !sp_reg)
        else $error("send request survived a poll");

    // no command byte without a send
    a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_send_reg) |-> res_cmd_reg == 8'd0)
        else $error("command byte set without send");

    // a tick in init starts fault clearing
    a_init_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_func_reg == FN_TICK && phase_reg == PH_INIT) |=>
        (phase_reg == PH_CLEAR && sp_reg))
        else $error("tick in init did not start the sequence");

    // status word is reported in its own result
    a_status_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_func_reg == FN_STATUS) |=> res_status_reg == $past(s1_status_reg))
        else $error("last status not updated");

endmodule
